### rtl/lps_pkg.sv
`default_nettype none
package lps_pkg;

  localparam int ColorW    = 24;
  localparam int CountW    = 8;
  localparam int IntervalW = 16;
  localparam int StepW     = 8;

  localparam logic [StepW-1:0]     FullLevel     = 8'hFF;
  localparam logic [StepW-1:0]     BootStepReset = 8'd4;
  localparam logic [IntervalW-1:0] ElapsedMax    = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_SOLID = 2'd1,
    OP_BLINK = 2'd2,
    OP_BOOT  = 2'd3
  } lps_op_t;

  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_BLINK = 2'd1,
    MODE_BOOT  = 2'd2,
    MODE_SOLID = 2'd3
  } lps_mode_t;

  typedef enum logic [1:0] {
    PHASE_RED_BLUE   = 2'd0,
    PHASE_BLUE_GREEN = 2'd1,
    PHASE_GREEN_RED  = 2'd2,
    PHASE_DONE       = 2'd3
  } lps_phase_t;

  typedef struct packed {
    logic [1:0]           operation;
    logic [ColorW-1:0]    color;
    logic [CountW-1:0]    blink_count;
    logic [IntervalW-1:0] blink_interval;
  } lps_item_t;

  typedef struct packed {
    logic [ColorW-1:0] led_color;
    logic              updated;
    logic [1:0]        pattern;
  } lps_result_t;

  function automatic logic [ColorW-1:0] fade_color(input lps_phase_t phase,
                                                   input logic [StepW-1:0] s);
    logic [StepW-1:0] down;
    logic [ColorW-1:0] c;
    down = FullLevel - s;
    case (phase)
      PHASE_RED_BLUE:   c = {down, 8'h00, s};
      PHASE_BLUE_GREEN: c = {8'h00, s, down};
      PHASE_GREEN_RED:  c = {s, down, 8'h00};
      default:          c = '0;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

### rtl/lps_in_if.sv
`default_nettype none
interface lps_in_if
  import lps_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [1:0]           operation;
  logic [ColorW-1:0]    color;
  logic [CountW-1:0]    blink_count;
  logic [IntervalW-1:0] blink_interval;

  modport source (output valid, output operation, output color, output blink_count,
                  output blink_interval, input ready);
  modport sink (input valid, input operation, input color, input blink_count,
                input blink_interval, output ready);
endinterface
`default_nettype wire

### rtl/lps_out_if.sv
`default_nettype none
interface lps_out_if
  import lps_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [ColorW-1:0] led_color;
  logic              updated;
  logic [1:0]        pattern;

  modport source (output valid, output led_color, output updated, output pattern,
                  input ready);
  modport sink (input valid, input led_color, input updated, input pattern,
                output ready);
endinterface
`default_nettype wire

### rtl/lps_in_stage.sv
`default_nettype none
module lps_in_stage
  import lps_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  lps_in_if.sink     in_ch,
  input  wire logic  advance,
  output logic       item_valid,
  output lps_item_t  item
);

  logic      valid_r;
  logic      valid_nxt;
  lps_item_t item_r;
  logic      take;

  assign in_ch.ready = !valid_r || advance;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= '{operation:      in_ch.operation,
                  color:          in_ch.color,
                  blink_count:    in_ch.blink_count,
                  blink_interval: in_ch.blink_interval};
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule
`default_nettype wire

### rtl/lps_engine.sv
`default_nettype none
module lps_engine
  import lps_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [StepW-1:0] cfg_wdata,
  input  wire logic             advance,
  input  wire lps_item_t        item,
  output lps_result_t           result
);

  logic [StepW-1:0]     boot_step_ticks_r;
  lps_mode_t            mode_r, mode_nxt;
  logic [ColorW-1:0]    solid_color_r, solid_color_nxt;
  logic [ColorW-1:0]    flash_color_r, flash_color_nxt;
  logic [CountW-1:0]    blinks_left_r, blinks_left_nxt;
  logic [IntervalW-1:0] half_period_r, half_period_nxt;
  logic [IntervalW-1:0] elapsed_r, elapsed_nxt;
  logic                 lamp_on_r, lamp_on_nxt;
  lps_phase_t           phase_r, phase_nxt;
  logic [StepW-1:0]     step_r, step_nxt;
  logic [ColorW-1:0]    shown_r, shown_nxt;
  logic                 upd;
  logic [IntervalW-1:0] elapsed_inc;

  // saturating tick count, shared by blink and boot
  assign elapsed_inc = (elapsed_r == ElapsedMax) ? elapsed_r : elapsed_r + 1'b1;

  always_comb begin
    mode_nxt        = mode_r;
    solid_color_nxt = solid_color_r;
    flash_color_nxt = flash_color_r;
    blinks_left_nxt = blinks_left_r;
    half_period_nxt = half_period_r;
    elapsed_nxt     = elapsed_r;
    lamp_on_nxt     = lamp_on_r;
    phase_nxt       = phase_r;
    step_nxt        = step_r;
    shown_nxt       = shown_r;
    upd             = 1'b0;
    case (item.operation)
      OP_SOLID: begin
        solid_color_nxt = item.color;
        mode_nxt        = MODE_SOLID;
        shown_nxt       = item.color;
        upd             = 1'b1;
      end
      OP_BLINK: begin
        mode_nxt        = MODE_BLINK;
        flash_color_nxt = item.color;
        blinks_left_nxt = item.blink_count;
        half_period_nxt = item.blink_interval;
        elapsed_nxt     = '0;
        lamp_on_nxt     = 1'b1;
        shown_nxt       = item.color;
        upd             = 1'b1;
      end
      OP_BOOT: begin
        mode_nxt    = MODE_BOOT;
        phase_nxt   = PHASE_RED_BLUE;
        step_nxt    = '0;
        elapsed_nxt = '0;
      end
      default: begin
        case (mode_r)
          MODE_BLINK: begin
            if (blinks_left_r == '0) begin
              shown_nxt = solid_color_r;
              mode_nxt  = MODE_SOLID;
              upd       = 1'b1;
            end else if (elapsed_inc < half_period_r) begin
              elapsed_nxt = elapsed_inc;
            end else begin
              if (lamp_on_r) begin
                shown_nxt       = '0;
                blinks_left_nxt = blinks_left_r - 1'b1;
              end else begin
                shown_nxt = flash_color_r;
              end
              lamp_on_nxt = !lamp_on_r;
              elapsed_nxt = '0;
              upd         = 1'b1;
            end
          end
          MODE_BOOT: begin
            if (elapsed_inc < {{(IntervalW-StepW){1'b0}}, boot_step_ticks_r}) begin
              elapsed_nxt = elapsed_inc;
            end else begin
              elapsed_nxt = '0;
              upd         = 1'b1;
              if (phase_r == PHASE_DONE) begin
                shown_nxt = '0;
                mode_nxt  = MODE_NONE;
                phase_nxt = PHASE_RED_BLUE;
                step_nxt  = '0;
              end else begin
                shown_nxt = fade_color(phase_r, step_r);
                if (step_r == FullLevel) begin
                  step_nxt  = '0;
                  phase_nxt = lps_phase_t'(phase_r + 2'd1);
                end else begin
                  step_nxt = step_r + 1'b1;
                end
              end
            end
          end
          MODE_SOLID: mode_nxt = MODE_NONE;
          default: ;
        endcase
      end
    endcase
  end

  assign result = '{led_color: shown_nxt, updated: upd, pattern: mode_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      boot_step_ticks_r <= BootStepReset;
      mode_r            <= MODE_NONE;
      solid_color_r     <= '0;
      flash_color_r     <= '0;
      blinks_left_r     <= '0;
      half_period_r     <= '0;
      elapsed_r         <= '0;
      lamp_on_r         <= 1'b0;
      phase_r           <= PHASE_RED_BLUE;
      step_r            <= '0;
      shown_r           <= '0;
    end else begin
      if (cfg_we) begin
        boot_step_ticks_r <= cfg_wdata;
      end
      if (advance) begin
        mode_r        <= mode_nxt;
        solid_color_r <= solid_color_nxt;
        flash_color_r <= flash_color_nxt;
        blinks_left_r <= blinks_left_nxt;
        half_period_r <= half_period_nxt;
        elapsed_r     <= elapsed_nxt;
        lamp_on_r     <= lamp_on_nxt;
        phase_r       <= phase_nxt;
        step_r        <= step_nxt;
        shown_r       <= shown_nxt;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/lps_out_stage.sv
`default_nettype none
module lps_out_stage
  import lps_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        load,
  input  wire lps_result_t result,
  output logic             free,
  lps_out_if.source        out_ch
);

  logic        valid_r;
  logic        valid_nxt;
  lps_result_t result_r;

  assign free = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result;
    end
  end

  assign out_ch.valid     = valid_r;
  assign out_ch.led_color = result_r.led_color;
  assign out_ch.updated   = result_r.updated;
  assign out_ch.pattern   = result_r.pattern;

endmodule
`default_nettype wire

### rtl/led_pattern_sequencer.sv
// Channel   Dir  Handshake       Payload
// in_ch     in   valid/ready     operation, color, blink_count, blink_interval
// out_ch    out  valid/ready     led_color, updated, pattern
// cfg       in   cfg_we          cfg_wdata = boot_step_ticks
//
// One item per cycle sustained while out_ch is not stalled; the result passes from
// the input accept through the input register, then the result register.
// The pattern state advances when the input register hands its item to the
// result register; a stalled result register holds the input register.
// rst_n is synchronous: pattern none, LED off, boot_step_ticks = 4.
`default_nettype none
module led_pattern_sequencer
  import lps_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  lps_in_if.sink                in_ch,
  lps_out_if.source             out_ch,
  input  wire logic             cfg_we,
  input  wire logic [StepW-1:0] cfg_wdata
);

  logic        item_valid;
  lps_item_t   item;
  lps_result_t result;
  logic        out_free;
  logic        advance;

  assign advance = item_valid && out_free;

  lps_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  lps_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .advance   (advance),
    .item      (item),
    .result    (result)
  );

  lps_out_stage u_out_stage (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (advance),
    .result (result),
    .free   (out_free),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire

### tb/led_pattern_sequencer_test.sv
`timescale 1ns / 100ps
module led_pattern_sequencer_test;
  import lps_pkg::*;

  localparam int QuietLimit = 1000;
  localparam int HoldCycles = 80;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [StepW-1:0] cfg_wdata;

  lps_in_if  in_ch ();
  lps_out_if out_ch ();

  led_pattern_sequencer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // sequencer state as the block should hold it
  logic [StepW-1:0]     step_ticks;
  lps_mode_t            mode;
  logic [ColorW-1:0]    solid_rgb;
  logic [ColorW-1:0]    flash_rgb;
  logic [ColorW-1:0]    shown_rgb;
  logic [CountW-1:0]    blinks_left;
  logic [IntervalW-1:0] half_period;
  logic [IntervalW-1:0] elapsed;
  logic                 lamp_on;
  lps_phase_t           fade_phase;
  logic [StepW-1:0]     fade_step;

  lps_item_t   cmd_queue[$];
  lps_result_t led_due[$];

  int  items_queued;
  int  items_in;
  int  results_out;
  int  errors;
  int  settings_used;
  int  in_gap;
  int  out_wait;
  int  hold_left;
  int  quiet;
  bit  in_busy;
  bit  in_eager;
  bit  out_eager;
  bit  hold_done;

  always #1 clk = ~clk;

  function automatic logic [ColorW-1:0] ramp_rgb(input lps_phase_t ph,
                                                 input logic [StepW-1:0] lvl);
    logic [StepW-1:0] dim;
    dim = 8'hFF - lvl;
    case (ph)
      PHASE_RED_BLUE:   return {dim, 8'h00, lvl};
      PHASE_BLUE_GREEN: return {8'h00, lvl, dim};
      PHASE_GREEN_RED:  return {lvl, dim, 8'h00};
      default:          return '0;
    endcase
  endfunction

  function automatic lps_result_t led_state_step(input lps_item_t it);
    lps_result_t r;
    logic        upd;
    upd = 1'b0;
    case (lps_op_t'(it.operation))
      OP_SOLID: begin
        solid_rgb = it.color;
        mode = MODE_SOLID;
        shown_rgb = it.color;
        upd = 1'b1;
      end
      OP_BLINK: begin
        mode = MODE_BLINK;
        flash_rgb = it.color;
        blinks_left = it.blink_count;
        half_period = it.blink_interval;
        elapsed = '0;
        lamp_on = 1'b1;
        shown_rgb = it.color;
        upd = 1'b1;
      end
      OP_BOOT: begin
        mode = MODE_BOOT;
        fade_phase = PHASE_RED_BLUE;
        fade_step = '0;
        elapsed = '0;
      end
      default: begin
        case (mode)
          MODE_BLINK: begin
            if (blinks_left == '0) begin
              shown_rgb = solid_rgb;
              mode = MODE_SOLID;
              upd = 1'b1;
            end else begin
              if (elapsed != ElapsedMax) elapsed++;
              if (elapsed >= half_period) begin
                if (lamp_on) begin
                  shown_rgb = '0;
                  blinks_left--;
                end else begin
                  shown_rgb = flash_rgb;
                end
                lamp_on = ~lamp_on;
                elapsed = '0;
                upd = 1'b1;
              end
            end
          end
          MODE_BOOT: begin
            if (elapsed != ElapsedMax) elapsed++;
            if (elapsed >= {8'h00, step_ticks}) begin
              elapsed = '0;
              upd = 1'b1;
              if (fade_phase == PHASE_DONE) begin
                // one step past the green-to-red ramp: LED off, idle
                shown_rgb = '0;
                mode = MODE_NONE;
                fade_phase = PHASE_RED_BLUE;
                fade_step = '0;
              end else begin
                shown_rgb = ramp_rgb(fade_phase, fade_step);
                if (fade_step == 8'hFF) begin
                  fade_step = '0;
                  fade_phase = lps_phase_t'(fade_phase + 2'd1);
                end else begin
                  fade_step++;
                end
              end
            end
          end
          MODE_SOLID: mode = MODE_NONE;
          default: ;
        endcase
      end
    endcase
    r.led_color = shown_rgb;
    r.updated = upd;
    r.pattern = mode;
    return r;
  endfunction

  task automatic push_item(input lps_op_t op, input logic [ColorW-1:0] rgb,
                           input logic [CountW-1:0] cnt, input logic [IntervalW-1:0] ivl);
    lps_item_t it;
    it.operation = op;
    it.color = rgb;
    it.blink_count = cnt;
    it.blink_interval = ivl;
    cmd_queue.push_back(it);
    items_queued++;
  endtask

  // ticks carry random junk in the unused fields
  task automatic push_ticks(input int n);
    repeat (n) push_item(OP_TICK, ColorW'($urandom), CountW'($urandom), IntervalW'($urandom));
  endtask

  task automatic random_episode();
    int kind;
    int cnt;
    int ivl;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2, 3: begin
        cnt = $urandom_range(0, 3);
        ivl = $urandom_range(0, 3);
        push_item(OP_BLINK, ColorW'($urandom), CountW'(cnt), IntervalW'(ivl));
        // mostly run the blink out, sometimes cut it short
        if ($urandom_range(0, 3) == 0) push_ticks($urandom_range(0, 4));
        else push_ticks(int'(2 * cnt * (ivl + 1) + $urandom_range(1, 3)));
      end
      4, 5: begin
        push_item(OP_SOLID, ColorW'($urandom), CountW'($urandom), IntervalW'($urandom));
        push_ticks($urandom_range(0, 2));
      end
      6, 7: begin
        push_item(OP_BOOT, ColorW'($urandom), CountW'($urandom), IntervalW'($urandom));
        push_ticks($urandom_range(1, 40));
      end
      default: begin
        repeat ($urandom_range(1, 3))
          push_item(lps_op_t'($urandom_range(0, 3)), ColorW'($urandom), CountW'($urandom),
                    IntervalW'($urandom));
      end
    endcase
  endtask

  task automatic random_run(input int n);
    int stop;
    stop = items_queued + n;
    while (items_queued < stop) random_episode();
  endtask

  task automatic wait_drained();
    while (cmd_queue.size() != 0 || in_busy || led_due.size() != 0) @(negedge clk);
  endtask

  task automatic write_step_ticks(input logic [StepW-1:0] v);
    wait_drained();
    repeat (4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    step_ticks = v;
    settings_used++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // input driver
  always @(negedge clk) begin
    lps_item_t it;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_busy) begin
      if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (cmd_queue.size() > 0) begin
        it = cmd_queue.pop_front();
        in_ch.operation <= it.operation;
        in_ch.color <= it.color;
        in_ch.blink_count <= it.blink_count;
        in_ch.blink_interval <= it.blink_interval;
        in_ch.valid <= 1'b1;
        in_busy = 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result ready, with one long hold-off once the run is well under way
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (!hold_done && results_out >= 300) begin
      hold_done = 1'b1;
      hold_left = HoldCycles - 1;
      out_ch.ready <= 1'b0;
    end else if (out_wait > 0) begin
      out_wait--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // accept tracking, prediction and result checking
  always @(posedge clk) begin
    lps_item_t   it;
    lps_result_t got;
    lps_result_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        it.operation = in_ch.operation;
        it.color = in_ch.color;
        it.blink_count = in_ch.blink_count;
        it.blink_interval = in_ch.blink_interval;
        led_due.push_back(led_state_step(it));
        in_busy = 1'b0;
        items_in++;
        if (items_in % 60 == 0) in_eager = !in_eager;
        in_gap = in_eager ? 0 : $urandom_range(0, 5);
      end
      if (out_ch.valid && out_ch.ready) begin
        got.led_color = out_ch.led_color;
        got.updated = out_ch.updated;
        got.pattern = out_ch.pattern;
        results_out++;
        if (led_due.size() == 0) begin
          $display("%0t: unexpected result, got color %06h updated %0b pattern %0d",
                   $time, got.led_color, got.updated, got.pattern);
          errors++;
        end else begin
          want = led_due.pop_front();
          if (got.led_color !== want.led_color) begin
            $display("%0t: led_color expected %06h, got %06h",
                     $time, want.led_color, got.led_color);
            errors++;
          end
          if (got.updated !== want.updated) begin
            $display("%0t: updated expected %0b, got %0b", $time, want.updated, got.updated);
            errors++;
          end
          if (got.pattern !== want.pattern) begin
            $display("%0t: pattern expected %0d, got %0d", $time, want.pattern, got.pattern);
            errors++;
          end
        end
        if (results_out % 45 == 0) out_eager = !out_eager;
        out_wait = out_eager ? 0 : $urandom_range(0, 5);
      end
    end
  end

  // watchdog on cycles with no accept on either side
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet = 0;
    else
      quiet++;
    if (quiet >= QuietLimit) begin
      $display("%0t: no progress for %0d cycles, %0d results outstanding",
               $time, quiet, led_due.size());
      $display("led_pattern_sequencer_test failed");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.operation = '0;
    in_ch.color = '0;
    in_ch.blink_count = '0;
    in_ch.blink_interval = '0;
    out_ch.ready = 1'b0;
    step_ticks = BootStepReset;
    mode = MODE_NONE;
    solid_rgb = '0;
    flash_rgb = '0;
    shown_rgb = '0;
    blinks_left = '0;
    half_period = '0;
    elapsed = '0;
    lamp_on = 1'b0;
    fade_phase = PHASE_RED_BLUE;
    fade_step = '0;
    in_eager = 1'b0;
    out_eager = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed, reset step setting of 4
    push_ticks(1);                                   // idle tick
    push_item(OP_SOLID, 24'hFFFFFF, 8'h00, 16'h0000);
    push_ticks(2);                                   // solid drops to none, then idle
    push_item(OP_SOLID, 24'h000000, 8'hFF, 16'hFFFF);
    push_item(OP_BLINK, 24'hA5A5A5, 8'h00, 16'h0000); // zero blinks
    push_ticks(1);
    push_item(OP_BLINK, 24'h123456, 8'h01, 16'h0000); // zero interval
    push_ticks(3);
    push_item(OP_BLINK, 24'hFFFFFF, 8'hFF, 16'hFFFF);
    push_ticks(2);
    push_item(OP_BOOT, 24'h5A5A5A, 8'h80, 16'h8000);
    push_ticks(9);
    push_item(OP_SOLID, 24'h00FF00, 8'h00, 16'h0000); // solid cuts the fade
    push_ticks(1);

    // whole fade to the off step at one step per tick
    write_step_ticks(8'd0);
    push_item(OP_BOOT, ColorW'($urandom), CountW'($urandom), IntervalW'($urandom));
    push_ticks(3 * 256 + 3);
    random_run(80);

    write_step_ticks(8'd255);
    push_item(OP_BOOT, ColorW'($urandom), CountW'($urandom), IntervalW'($urandom));
    push_ticks(257);
    random_run(80);

    write_step_ticks(8'd1);
    random_run(100);

    write_step_ticks(8'($urandom_range(2, 30)));
    random_run(100);

    wait_drained();
    repeat (8) @(posedge clk);
    $display("Ran %0d items and checked %0d results over %0d step settings,",
             items_in, results_out, settings_used);
    $display("with a full boot fade, blink runs, and a %0d-cycle output stall.", HoldCycles);
    if (errors == 0)
      $display("led_pattern_sequencer_test passed");
    else
      $display("led_pattern_sequencer_test failed");
    $finish;
  end

endmodule

### filelist.f
rtl/lps_pkg.sv
rtl/lps_in_if.sv
rtl/lps_out_if.sv
rtl/lps_in_stage.sv
rtl/lps_engine.sv
rtl/lps_out_stage.sv
rtl/led_pattern_sequencer.sv
tb/led_pattern_sequencer_test.sv
